// ===== hw/rtl/gregorian_serial_date_codec_core_assert.svh =====
// Assertion macros for the Gregorian serial date codec.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef GREGORIAN_SERIAL_DATE_CODEC_CORE_ASSERT_SVH
`define GREGORIAN_SERIAL_DATE_CODEC_CORE_ASSERT_SVH
`ifndef SYNTH
`define GSDC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define GSDC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define GSDC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define GSDC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/gsdc_pkg.sv =====
// Shared types, constants and calendar functions of the serial date codec.
// No dependencies; used by gsdc_enc, gsdc_dec and the top level.
package gsdc_pkg;

  typedef enum logic [1:0] {
    CMD_ENCODE = 2'd0,
    CMD_DECODE = 2'd1,
    CMD_OFFSET = 2'd2
  } cmd_t;

  localparam int unsigned ENC_STAGES = 3;
  localparam int unsigned DEC_STAGES = 9;

  // Zero-based day index: 0 is 0001-01-01, day number = index - IDX_BIAS.
  localparam logic [21:0] IDX_BIAS = 22'd693593;
  localparam logic [21:0] IDX_MAX  = 22'd3652058;
  localparam logic [13:0] YEAR_MAX = 14'd9999;

  localparam logic [17:0] D400 = 18'd146097;
  localparam logic [15:0] D100 = 16'd36524;
  localparam logic [10:0] D4   = 11'd1461;
  localparam logic [8:0]  D1   = 9'd365;

  // Rounded-up reciprocals, exact floor over the operand ranges used.
  localparam int unsigned K400 = 40;
  localparam int unsigned K4   = 26;
  localparam int unsigned K25  = 16;
  localparam logic [22:0] M400 = 23'(((64'd1 << K400) + 64'(D400) - 64'd1) / 64'(D400));
  localparam logic [15:0] M4   = 16'(((64'd1 << K4) + 64'(D4) - 64'd1) / 64'(D4));
  localparam logic [11:0] M25  = 12'(((64'd1 << K25) + 64'd24) / 64'd25);

  typedef struct packed {
    logic               enc;
    logic               ok;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [22:0] dn;
  } side_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [23:0]        idx_dec;
    logic signed [22:0] off;
  } req_t;

  // Days of the year before the first of month m (zero-based day of year).
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r + 9'(leap && (m > 4'd2));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
      4'd2:                                       r = leap ? 5'd29 : 5'd28;
      default:                                    r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/gsdc_enc.sv =====
// Date to zero-based day index: three pipeline stages with validity check.
// Depends on gsdc_pkg and the assertion header.
`include "gregorian_serial_date_codec_core_assert.svh"

module gsdc_enc (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_vld,
  input  logic [13:0] year,
  input  logic [3:0]  month,
  input  logic [4:0]  day,
  output logic        out_vld,
  output logic        out_ok,
  output logic [21:0] out_idx
);

  logic [13:0] p_in;
  logic [23:0] prod_y;
  logic [23:0] prod_p;

  logic        s1_vld;
  logic [13:0] s1_year;
  logic [3:0]  s1_month;
  logic [4:0]  s1_day;
  logic [7:0]  s1_qy;
  logic [7:0]  s1_qp;
  logic        s1_yok;
  logic        s1_mok;

  logic [13:0] s1_p;
  logic [11:0] s1_ry;
  logic        s1_leap;
  logic [4:0]  s1_dim;
  logic        s1_dok;

  logic        s2_vld;
  logic        s2_ok;
  logic [21:0] s2_base;
  logic [8:0]  s2_doy;

  logic        s3_vld;
  logic        s3_ok;
  logic [21:0] s3_idx;

  // year/100 and (year-1)/100 through a reciprocal of 25 on year>>2
  assign p_in   = year - 14'd1;
  assign prod_y = 24'(year[13:2]) * 24'(gsdc_pkg::M25);
  assign prod_p = 24'(p_in[13:2]) * 24'(gsdc_pkg::M25);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
    end else begin
      s1_vld <= in_vld;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    s1_year  <= year;
    s1_month <= month;
    s1_day   <= day;
    s1_qy    <= prod_y[23:16];
    s1_qp    <= prod_p[23:16];
    s1_yok   <= (year != 14'd0) && (year <= gsdc_pkg::YEAR_MAX);
    s1_mok   <= (month != 4'd0) && (month <= 4'd12);
  end

  always_comb begin
    s1_p    = s1_year - 14'd1;
    s1_ry   = s1_year[13:2] - 12'(12'(s1_qy) * 12'd25);
    // century years are leap only when year/400 has no remainder
    s1_leap = (s1_year[1:0] == 2'd0) && ((s1_ry != 12'd0) || (s1_qy[1:0] == 2'd0));
    s1_dim  = gsdc_pkg::month_days(s1_month, s1_leap);
    s1_dok  = (s1_day != 5'd0) && (s1_day <= s1_dim);
  end

  always_ff @(posedge clk) begin
    s2_ok   <= s1_yok && s1_mok && s1_dok;
    s2_base <= 22'(s1_p) * 22'd365 + 22'(s1_p[13:2]) - 22'(s1_qp) + 22'(s1_qp[7:2]);
    s2_doy  <= gsdc_pkg::month_start(s1_month, s1_leap) + 9'(s1_day);
  end

  always_ff @(posedge clk) begin
    s3_ok  <= s2_ok;
    s3_idx <= s2_base + 22'(s2_doy) - 22'd1;
  end

  assign out_vld = s3_vld;
  assign out_ok  = s3_ok;
  assign out_idx = s3_idx;

  `GSDC_ASSERT_IMP(a_enc_idx_range, clk, rst, s3_vld && s3_ok, s3_idx <= gsdc_pkg::IDX_MAX, "encoded index beyond year 9999")

endmodule

// ===== hw/rtl/gsdc_dec.sv =====
// Zero-based day index to year, month and day: nine pipeline stages.
// Depends on gsdc_pkg and the assertion header; side data rides along unchanged.
`include "gregorian_serial_date_codec_core_assert.svh"

module gsdc_dec (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [21:0]       in_idx,
  input  gsdc_pkg::side_t   in_side,
  output logic              out_vld,
  output logic [13:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day,
  output gsdc_pkg::side_t   out_side
);

  logic [gsdc_pkg::DEC_STAGES-1:0] vld_q;
  gsdc_pkg::side_t                 side_q [gsdc_pkg::DEC_STAGES];

  logic [44:0] prod400;
  logic [21:0] t1_idx;
  logic [4:0]  t1_q400;

  logic [4:0]  t2_q400;
  logic [17:0] t2_r400;

  logic [1:0]  q100;
  logic [4:0]  t3_q400;
  logic [1:0]  t3_q100;
  logic [15:0] t3_r100;

  logic [31:0] prod4;
  logic [4:0]  t4_q400;
  logic [1:0]  t4_q100;
  logic [5:0]  t4_q4;
  logic [15:0] t4_r100;

  logic [4:0]  t5_q400;
  logic [1:0]  t5_q100;
  logic [5:0]  t5_q4;
  logic [10:0] t5_r4;

  logic [1:0]  q1;
  logic [4:0]  t6_q400;
  logic [1:0]  t6_q100;
  logic [5:0]  t6_q4;
  logic [1:0]  t6_q1;
  logic [8:0]  t6_r1;

  logic [13:0] t7_year;
  logic        t7_leap;
  logic [8:0]  t7_r1;

  logic [3:0]  mon;
  logic [13:0] t8_year;
  logic        t8_leap;
  logic [8:0]  t8_r1;
  logic [3:0]  t8_month;

  logic [13:0] t9_year;
  logic [3:0]  t9_month;
  logic [4:0]  t9_day;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[gsdc_pkg::DEC_STAGES-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    side_q[0] <= in_side;
    for (int i = 1; i < gsdc_pkg::DEC_STAGES; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // 400-year cycles
  assign prod400 = 45'(in_idx) * 45'(gsdc_pkg::M400);

  always_ff @(posedge clk) begin
    t1_idx  <= in_idx;
    t1_q400 <= prod400[44:40];
  end

  always_ff @(posedge clk) begin
    t2_q400 <= t1_q400;
    t2_r400 <= 18'(t1_idx - 22'(22'(t1_q400) * 22'(gsdc_pkg::D400)));
  end

  // centuries; last day of a 400-year cycle stays in the fourth century
  always_comb begin
    if (t2_r400 >= 18'(3 * gsdc_pkg::D100)) begin
      q100 = 2'd3;
    end else if (t2_r400 >= 18'(2 * gsdc_pkg::D100)) begin
      q100 = 2'd2;
    end else if (t2_r400 >= 18'(gsdc_pkg::D100)) begin
      q100 = 2'd1;
    end else begin
      q100 = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    t3_q400 <= t2_q400;
    t3_q100 <= q100;
    t3_r100 <= 16'(t2_r400 - 18'(18'(q100) * 18'(gsdc_pkg::D100)));
  end

  // 4-year cycles
  assign prod4 = 32'(t3_r100) * 32'(gsdc_pkg::M4);

  always_ff @(posedge clk) begin
    t4_q400 <= t3_q400;
    t4_q100 <= t3_q100;
    t4_q4   <= prod4[31:26];
    t4_r100 <= t3_r100;
  end

  always_ff @(posedge clk) begin
    t5_q400 <= t4_q400;
    t5_q100 <= t4_q100;
    t5_q4   <= t4_q4;
    t5_r4   <= 11'(t4_r100 - 16'(16'(t4_q4) * 16'(gsdc_pkg::D4)));
  end

  // years within the 4-year cycle, last day held in the fourth year
  always_comb begin
    if (t5_r4 >= 11'(3 * gsdc_pkg::D1)) begin
      q1 = 2'd3;
    end else if (t5_r4 >= 11'(2 * gsdc_pkg::D1)) begin
      q1 = 2'd2;
    end else if (t5_r4 >= 11'(gsdc_pkg::D1)) begin
      q1 = 2'd1;
    end else begin
      q1 = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    t6_q400 <= t5_q400;
    t6_q100 <= t5_q100;
    t6_q4   <= t5_q4;
    t6_q1   <= q1;
    t6_r1   <= 9'(t5_r4 - 11'(11'(q1) * 11'(gsdc_pkg::D1)));
  end

  // leap: fourth year of its 4-year cycle, unless a century not on a 400 boundary
  always_ff @(posedge clk) begin
    t7_year <= 14'(t6_q400) * 14'd400 + 14'(t6_q100) * 14'd100 + 14'(t6_q4) * 14'd4
               + 14'(t6_q1) + 14'd1;
    t7_leap <= (t6_q1 == 2'd3) && ((t6_q4 != 6'd24) || (t6_q100 == 2'd3));
    t7_r1   <= t6_r1;
  end

  always_comb begin
    mon = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (t7_r1 >= gsdc_pkg::month_start(4'(k), t7_leap)) begin
        mon = 4'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    t8_year  <= t7_year;
    t8_leap  <= t7_leap;
    t8_r1    <= t7_r1;
    t8_month <= mon;
  end

  always_ff @(posedge clk) begin
    t9_year  <= t8_year;
    t9_month <= t8_month;
    t9_day   <= 5'(t8_r1 - gsdc_pkg::month_start(t8_month, t8_leap) + 9'd1);
  end

  assign out_vld  = vld_q[gsdc_pkg::DEC_STAGES-1];
  assign out_side = side_q[gsdc_pkg::DEC_STAGES-1];
  assign year     = t9_year;
  assign month    = t9_month;
  assign day      = t9_day;

  `GSDC_ASSERT_IMP(a_dec_year_range, clk, rst, out_vld && out_side.ok && !out_side.enc, (t9_year != 14'd0) && (t9_year <= gsdc_pkg::YEAR_MAX), "decoded year out of range")
  `GSDC_ASSERT_IMP(a_dec_date_shape, clk, rst, out_vld && out_side.ok && !out_side.enc, (t9_month != 4'd0) && (t9_month <= 4'd12) && (t9_day != 5'd0) && (t9_day <= 5'd31), "decoded month or day out of range")

endmodule

// ===== hw/rtl/gregorian_serial_date_codec_core.sv =====
// Top level of the Gregorian serial date codec: command select, sum, range check.
// Depends on gsdc_pkg, gsdc_enc, gsdc_dec and the assertion header.
//
// Channel  Dir  Handshake            Fields
// request  in   start, busy          cmd, year, month, day, day_number, offset_days
// result   out  done (one cycle)     valid_res, year_out, month_out, day_out, day_number_out
//
// One request per clock while busy is low; each result is strobed on done.
// The pipeline has 3 encode stages, 1 select/add, 9 decode and 1 output register.
// rst is synchronous and clears the valid bits; busy is high only during reset.
// Results are shown for one cycle each and cannot be held off.
`include "gregorian_serial_date_codec_core_assert.svh"

module gregorian_serial_date_codec_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [13:0]        year,
  input  logic [3:0]         month,
  input  logic [4:0]         day,
  input  logic signed [22:0] day_number,
  input  logic signed [22:0] offset_days,
  output logic               done,
  output logic               valid_res,
  output logic [13:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic signed [22:0] day_number_out
);

  logic                take;
  gsdc_pkg::req_t      req_in;
  gsdc_pkg::req_t      req_q [gsdc_pkg::ENC_STAGES];
  gsdc_pkg::req_t      req;

  logic                enc_vld;
  logic                enc_ok;
  logic [21:0]         enc_idx;

  logic [23:0]         off_ext;
  logic [23:0]         sum;
  logic                range_ok;
  gsdc_pkg::side_t     side_next;

  logic                sel_vld;
  logic [21:0]         sel_idx;
  gsdc_pkg::side_t     sel_side;

  logic                dec_vld;
  logic [13:0]         dec_year;
  logic [3:0]          dec_month;
  logic [4:0]          dec_day;
  gsdc_pkg::side_t     dec_side;

  assign busy = rst;
  assign take = start && !busy;

  always_comb begin
    req_in.cmd     = gsdc_pkg::cmd_t'(cmd);
    req_in.year    = year;
    req_in.month   = month;
    req_in.day     = day;
    req_in.idx_dec = {day_number[22], day_number} + 24'(gsdc_pkg::IDX_BIAS);
    req_in.off     = offset_days;
  end

  // request fields wait here while the date is encoded
  always_ff @(posedge clk) begin
    req_q[0] <= req_in;
    for (int i = 1; i < gsdc_pkg::ENC_STAGES; i++) begin
      req_q[i] <= req_q[i-1];
    end
  end

  assign req = req_q[gsdc_pkg::ENC_STAGES-1];

  gsdc_enc u_enc (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (take),
    .year    (year),
    .month   (month),
    .day     (day),
    .out_vld (enc_vld),
    .out_ok  (enc_ok),
    .out_idx (enc_idx)
  );

  always_comb begin
    off_ext  = {req.off[22], req.off};
    sum      = (req.cmd == gsdc_pkg::CMD_OFFSET) ? ({2'b00, enc_idx} + off_ext) : req.idx_dec;
    range_ok = !sum[23] && (sum[22:0] <= 23'(gsdc_pkg::IDX_MAX));

    side_next.enc   = 1'b0;
    side_next.ok    = 1'b0;
    side_next.year  = req.year;
    side_next.month = req.month;
    side_next.day   = req.day;
    side_next.dn    = 23'({1'b0, enc_idx} - 23'(gsdc_pkg::IDX_BIAS));
    case (req.cmd)
      gsdc_pkg::CMD_ENCODE: begin
        side_next.enc = 1'b1;
        side_next.ok  = enc_ok;
      end
      gsdc_pkg::CMD_DECODE: begin
        side_next.ok = range_ok;
      end
      gsdc_pkg::CMD_OFFSET: begin
        side_next.ok = enc_ok && range_ok;
      end
      default: begin
        side_next.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_vld <= 1'b0;
    end else begin
      sel_vld <= enc_vld;
    end
  end

  always_ff @(posedge clk) begin
    sel_idx  <= sum[21:0];
    sel_side <= side_next;
  end

  gsdc_dec u_dec (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sel_vld),
    .in_idx   (sel_idx),
    .in_side  (sel_side),
    .out_vld  (dec_vld),
    .year     (dec_year),
    .month    (dec_month),
    .day      (dec_day),
    .out_side (dec_side)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= 1'b0;
      valid_res <= 1'b0;
    end else begin
      done      <= dec_vld;
      valid_res <= dec_vld && dec_side.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!dec_side.ok) begin
      year_out       <= '0;
      month_out      <= '0;
      day_out        <= '0;
      day_number_out <= '0;
    end else if (dec_side.enc) begin
      year_out       <= dec_side.year;
      month_out      <= dec_side.month;
      day_out        <= dec_side.day;
      day_number_out <= dec_side.dn;
    end else begin
      year_out       <= dec_year;
      month_out      <= dec_month;
      day_out        <= dec_day;
      day_number_out <= '0;
    end
  end

  `GSDC_ASSERT_IMP(a_valid_with_done, clk, rst, valid_res, done, "valid_res without result strobe")
  `GSDC_ASSERT_IMP(a_reject_zeroed, clk, rst, done && !valid_res, (year_out == 14'd0) && (month_out == 4'd0) && (day_out == 5'd0) && (day_number_out == 23'sd0), "rejected request with nonzero fields")

endmodule
